>>> hw/rtl/sha1_pkg.sv
// sha1_pkg: shared types, constants and helpers for the sha1 hash block
// no dependencies; imported by sha1_round, sha1_wbuf, sha1_hash and tb_top
package sha1_pkg;

  // input word kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_LAST = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // initial chaining values
  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  // round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int unsigned ROUNDS = 80;

  // working variables of the compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  // control of the block buffer
  typedef struct packed {
    logic        put;     // store one message byte at pos
    logic        pad;     // 0x80 at pos, zero after it
    logic        clr;     // zero the whole block
    logic        len;     // bit length into words 14 and 15
    logic        shift;   // schedule shift for one round
    logic        expand;  // round 16 and up: derive schedule word
    logic [5:0]  pos;
    logic [7:0]  data;
    logic [63:0] bits;
  } wbuf_ctl_t;

  function automatic logic [31:0] rol1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

endpackage

>>> hw/rtl/sha1_round.sv
// sha1_round: one sha-1 round, shared over all 80 rounds of a block
// depends on sha1_pkg
module sha1_round import sha1_pkg::*; (
  input  work_t       cur_i,
  input  logic [31:0] w_i,
  input  logic [6:0]  rnd_i,
  output work_t       nxt_o
);

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (rnd_i < 7'd20) begin
      f = (cur_i.b & cur_i.c) | (~cur_i.b & cur_i.d);
      k = K0;
    end else if (rnd_i < 7'd40) begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = K1;
    end else if (rnd_i < 7'd60) begin
      f = (cur_i.b & cur_i.c) | (cur_i.b & cur_i.d) | (cur_i.c & cur_i.d);
      k = K2;
    end else begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = K3;
    end
  end

  always_comb begin
    nxt_o.a = {cur_i.a[26:0], cur_i.a[31:27]} + f + cur_i.e + k + w_i;
    nxt_o.b = cur_i.a;
    nxt_o.c = {cur_i.b[1:0], cur_i.b[31:2]};
    nxt_o.d = cur_i.c;
    nxt_o.e = cur_i.d;
  end

endmodule

>>> hw/rtl/sha1_wbuf.sv
// sha1_wbuf: 16-word block buffer, byte packing, padding and schedule shift line
// depends on sha1_pkg
module sha1_wbuf import sha1_pkg::*; (
  input  logic        clk,
  input  wbuf_ctl_t   ctl_i,
  output logic [31:0] w_o
);

  logic [31:0] blk_r   [16];
  logic [31:0] blk_nxt [16];

  // schedule taps: blk_r[0] holds w[r-16], [2] w[r-14], [8] w[r-8], [13] w[r-3]
  assign w_o = ctl_i.expand ? rol1(blk_r[13] ^ blk_r[8] ^ blk_r[2] ^ blk_r[0])
                            : blk_r[0];

  always_comb begin
    logic [5:0] p;
    p = '0;
    for (int j = 0; j < 16; j++) begin
      blk_nxt[j] = blk_r[j];
    end
    if (ctl_i.put || ctl_i.pad) begin
      for (int j = 0; j < 16; j++) begin
        for (int b = 0; b < 4; b++) begin
          p = 6'(j * 4 + b);
          if (p == ctl_i.pos) begin
            blk_nxt[j][31 - 8 * b -: 8] = ctl_i.put ? ctl_i.data : PAD_BYTE;
          end else if (ctl_i.pad && p > ctl_i.pos) begin
            blk_nxt[j][31 - 8 * b -: 8] = 8'h00;
          end
        end
      end
    end
    if (ctl_i.clr) begin
      for (int j = 0; j < 16; j++) begin
        blk_nxt[j] = 32'h0;
      end
    end
    if (ctl_i.len) begin
      blk_nxt[14] = ctl_i.bits[63:32];
      blk_nxt[15] = ctl_i.bits[31:0];
    end
    if (ctl_i.shift) begin
      for (int j = 0; j < 15; j++) begin
        blk_nxt[j] = blk_r[j + 1];
      end
      blk_nxt[15] = w_o;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 16; j++) begin
      blk_r[j] <= blk_nxt[j];
    end
  end

endmodule

>>> hw/rtl/sha1_hash.sv
// sha1_hash: byte-serial sha-1 engine, one shared round unit
// a byte that does not close a block is taken while idle; a byte that closes a block
// keeps the engine busy through load, the rounds and the chain add, and no byte is
// taken meanwhile; end of message: a pad step and one compression, plus a length
// step and one more compression when the length spills into a second block, then
// five digest words, one per cycle at best
// reset (rst_n, synchronous): idle, chaining words at their initial values, count 0
module sha1_hash import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;  // append 0x80, zero fill, and the length if it fits
  localparam logic [2:0] ST_LEN  = 3'd2;  // second block: zeros and bit length
  localparam logic [2:0] ST_RND  = 3'd3;  // one round per cycle
  localparam logic [2:0] ST_ADD  = 3'd4;  // fold working vars into chain
  localparam logic [2:0] ST_OUT  = 3'd5;  // digest words out

  // where to go after a compression
  localparam logic [1:0] CONT_IDLE = 2'd0;
  localparam logic [1:0] CONT_PAD  = 2'd1;
  localparam logic [1:0] CONT_LEN  = 2'd2;
  localparam logic [1:0] CONT_DONE = 2'd3;

  localparam logic [6:0] LAST_RND = 7'(ROUNDS - 1);

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  cont_r, cont_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [60:0] count_r, count_nxt;
  logic [31:0] chain_r [5];
  logic [31:0] chain_nxt [5];
  work_t       work_r, work_nxt;
  work_t       round_out;
  wbuf_ctl_t   ctl;
  logic [31:0] w;
  logic        in_acc;
  logic [5:0]  pos;
  work_t       chain_work;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign in_acc    = in_valid && in_ready;
  assign pos       = count_r[5:0];

  assign out_digest_word = chain_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd4);

  // chaining words as a working set, loaded at the start of each block
  assign chain_work = '{a: chain_r[0], b: chain_r[1], c: chain_r[2],
                        d: chain_r[3], e: chain_r[4]};

  sha1_wbuf u_wbuf (
    .clk   (clk),
    .ctl_i (ctl),
    .w_o   (w)
  );

  sha1_round u_round (
    .cur_i (work_r),
    .w_i   (w),
    .rnd_i (rnd_r),
    .nxt_o (round_out)
  );

  always_comb begin
    state_nxt = state_r;
    cont_nxt  = cont_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    work_nxt  = work_r;
    for (int i = 0; i < 5; i++) begin
      chain_nxt[i] = chain_r[i];
    end
    ctl        = '0;
    ctl.pos    = pos;
    ctl.data   = in_data_byte;
    ctl.bits   = {count_r, 3'b000};  // bit length wraps with the count
    ctl.expand = (rnd_r >= 7'd16);

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind inside {KIND_BYTE, KIND_LAST}) begin
            ctl.put   = 1'b1;
            count_nxt = count_r + 61'd1;
            if (pos == 6'd63) begin
              // block full: compress, then either idle or pad
              work_nxt  = chain_work;
              rnd_nxt   = '0;
              cont_nxt  = (in_kind == KIND_LAST) ? CONT_PAD : CONT_IDLE;
              state_nxt = ST_RND;
            end else if (in_kind == KIND_LAST) begin
              state_nxt = ST_PAD;
            end
          end else if (in_kind == KIND_END) begin
            state_nxt = ST_PAD;
          end
          // undefined kind: word dropped, nothing changes
        end
      end
      ST_PAD: begin
        ctl.pad = 1'b1;
        if (pos >= 6'd56) begin
          // no room for the length: it goes into a second block
          cont_nxt = CONT_LEN;
        end else begin
          ctl.len  = 1'b1;
          cont_nxt = CONT_DONE;
        end
        work_nxt  = chain_work;
        rnd_nxt   = '0;
        state_nxt = ST_RND;
      end
      ST_LEN: begin
        ctl.clr   = 1'b1;
        ctl.len   = 1'b1;
        cont_nxt  = CONT_DONE;
        work_nxt  = chain_work;
        rnd_nxt   = '0;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        ctl.shift = 1'b1;
        work_nxt  = round_out;
        rnd_nxt   = rnd_r + 7'd1;
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_nxt[0] = chain_r[0] + work_r.a;
        chain_nxt[1] = chain_r[1] + work_r.b;
        chain_nxt[2] = chain_r[2] + work_r.c;
        chain_nxt[3] = chain_r[3] + work_r.d;
        chain_nxt[4] = chain_r[4] + work_r.e;
        case (cont_r)
          CONT_IDLE: state_nxt = ST_IDLE;
          CONT_PAD:  state_nxt = ST_PAD;
          CONT_LEN:  state_nxt = ST_LEN;
          default: begin
            idx_nxt   = '0;
            state_nxt = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (out_ready) begin
          if (idx_r == 3'd4) begin
            // digest delivered: back to the initial hash state
            chain_nxt[0] = H0_INIT;
            chain_nxt[1] = H1_INIT;
            chain_nxt[2] = H2_INIT;
            chain_nxt[3] = H3_INIT;
            chain_nxt[4] = H4_INIT;
            count_nxt    = '0;
            idx_nxt      = '0;
            state_nxt    = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cont_r     <= CONT_IDLE;
      rnd_r      <= '0;
      idx_r      <= '0;
      count_r    <= '0;
      chain_r[0] <= H0_INIT;
      chain_r[1] <= H1_INIT;
      chain_r[2] <= H2_INIT;
      chain_r[3] <= H3_INIT;
      chain_r[4] <= H4_INIT;
    end else begin
      state_r <= state_nxt;
      cont_r  <= cont_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

`ifndef SYNTHESIS
  // input and output sides are never open together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest words pending");

  // round counter stays inside the 80 rounds
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RND) |-> (rnd_r <= LAST_RND))
    else $error("round counter out of range");

  // after the fifth word the engine is idle with a fresh count
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (in_ready && count_r == '0))
    else $error("engine not reset after digest");

  // digest words are only shown after a chain add
  a_out_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == ST_ADD))
    else $error("digest output entered without compression");
`endif

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking testbench for the byte-serial sha-1 engine sha1_hash
// depends on sha1_pkg (word kinds) and sha1_hash; message words in, digest words out
`timescale 1ns / 100ps

module tb_top import sha1_pkg::*; ();

  // kind value with no meaning; the engine must drop the word without effect
  localparam logic [1:0] KIND_RSVD = 2'd3;

  // one expected digest word as it should leave the engine
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = KIND_BYTE;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // shadow copy of the hashing state, advanced on every accepted word
  logic [31:0] chain_q [5];
  logic [31:0] block_q [16];
  logic [60:0] msg_bytes_q;

  digest_word_t digest_exp_q[$];

  // idling switches for the sender and the receiver
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  int unsigned stall_left = 0;

  int unsigned words_sent = 0;
  int unsigned messages_hashed = 0;
  int unsigned digest_words_checked = 0;
  int unsigned mismatch_count = 0;

  sha1_hash i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digest_word(out_digest_word),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sha-1 predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // back to the state of a fresh message
  function automatic void clear_hash_state();
    chain_q[0] = 32'h67452301;
    chain_q[1] = 32'hEFCDAB89;
    chain_q[2] = 32'h98BADCFE;
    chain_q[3] = 32'h10325476;
    chain_q[4] = 32'hC3D2E1F0;
    for (int i = 0; i < 16; i++) block_q[i] = 32'h0;
    msg_bytes_q = '0;
  endfunction

  // 80 rounds over block_q, folded into the chaining words
  function automatic void compress_block();
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e, f, k, w, t;
    for (int i = 0; i < 16; i++) sched[i] = block_q[i];
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    e = chain_q[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = sched[r];
      end else begin
        w = rotl(sched[(r - 3) % 16] ^ sched[(r - 8) % 16] ^
                 sched[(r - 14) % 16] ^ sched[r % 16], 1);
        sched[r % 16] = w;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
    chain_q[4] += e;
  endfunction

  // big-endian byte lane within the block
  function automatic void place_byte(input logic [5:0] pos, input logic [7:0] v);
    block_q[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = v;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    logic [5:0] pos;
    pos = msg_bytes_q[5:0];
    place_byte(pos, v);
    msg_bytes_q = msg_bytes_q + 61'd1;  // wraps at 2^61 on its own
    if (pos == 6'd63) compress_block();
  endfunction

  // padding, length, final compression(s); queues the five digest words
  function automatic void close_message();
    logic [5:0]   pos;
    logic [63:0]  bit_len;
    digest_word_t dw;
    pos = msg_bytes_q[5:0];
    bit_len = {msg_bytes_q, 3'b000};
    place_byte(pos, 8'h80);
    for (int i = pos + 1; i < 64; i++) place_byte(i[5:0], 8'h00);
    // no room left for the length: it spills into one more block
    if (pos >= 6'd56) begin
      compress_block();
      for (int i = 0; i < 16; i++) block_q[i] = 32'h0;
    end
    block_q[14] = bit_len[63:32];
    block_q[15] = bit_len[31:0];
    compress_block();
    for (int i = 0; i < 5; i++) begin
      dw.word  = chain_q[i];
      dw.index = i[2:0];
      dw.last  = (i == 4);
      digest_exp_q.push_back(dw);
    end
    messages_hashed++;
    clear_hash_state();
  endfunction

  function automatic void predict_word(input logic [1:0] kind, input logic [7:0] v);
    case (kind)
      KIND_BYTE: begin
        absorb_byte(v);
      end
      KIND_LAST: begin
        absorb_byte(v);
        close_message();
      end
      KIND_END: begin
        close_message();
      end
      default: begin
        // reserved kind: dropped, nothing changes
      end
    endcase
  endfunction

  initial clear_hash_state();

  // ---------------------------------------------------------------------------
  // scoreboard: predict on input handshake, compare on output handshake
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    // keep the log bounded if the engine is badly off
    if (mismatch_count <= 40)
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_word(in_kind, in_data_byte);
      if (out_valid && out_ready) begin
        if (digest_exp_q.size() == 0) begin
          report_mismatch("unexpected digest word", out_digest_word, 32'h0);
        end else begin
          if (out_digest_word !== digest_exp_q[0].word)
            report_mismatch("digest word", out_digest_word, digest_exp_q[0].word);
          if (out_word_index !== digest_exp_q[0].index)
            report_mismatch("word index", 32'(out_word_index),
                            32'(digest_exp_q[0].index));
          if (out_last_word !== digest_exp_q[0].last)
            report_mismatch("last word flag", 32'(out_last_word),
                            32'(digest_exp_q[0].last));
          void'(digest_exp_q.pop_front());
          digest_words_checked++;
        end
      end
    end
  end

  // receiver back-pressure: ready drops in random bursts while sink idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // drive one word and hold it until the engine takes it; valid is only
  // dropped when a gap follows, so back-to-back words keep it high
  task automatic send_word(input logic [1:0] kind, input logic [7:0] v);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data_byte <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind != KIND_RSVD) words_sent++;
  endtask

  // random message of len bytes; ends on a last byte or on a separate
  // end marker, with the odd reserved word thrown in as noise
  task automatic send_message(input int unsigned len);
    bit close_on_byte;
    close_on_byte = (len != 0) && $urandom_range(0, 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_word(KIND_RSVD, 8'($urandom_range(0, 255)));
      if (close_on_byte && i == len - 1)
        send_word(KIND_LAST, 8'($urandom_range(0, 255)));
      else
        send_word(KIND_BYTE, 8'($urandom_range(0, 255)));
    end
    if (!close_on_byte) send_word(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  // two empty messages, each closed by the end marker alone (its data is ignored)
  task automatic test_empty_message();
    send_word(KIND_END, 8'hFF);
    send_word(KIND_END, 8'h00);
  endtask

  // "abc", the classic short vector, ending on a last byte
  task automatic test_short_message();
    send_word(KIND_BYTE, 8'h61);
    send_word(KIND_BYTE, 8'h62);
    send_word(KIND_LAST, 8'h63);
  endtask

  // one-byte messages with the byte at its extremes, then a two-byte message of both closed by the end marker
  task automatic test_byte_extremes();
    send_word(KIND_LAST, 8'h00);
    send_word(KIND_LAST, 8'hFF);
    send_word(KIND_BYTE, 8'hFF);
    send_word(KIND_BYTE, 8'h00);
    send_word(KIND_END, 8'h5A);
  endtask

  // reserved kind at the start and in the middle of a message
  task automatic test_reserved_kind();
    send_word(KIND_RSVD, 8'hFF);
    send_word(KIND_BYTE, 8'h55);
    send_word(KIND_RSVD, 8'hAA);
    send_word(KIND_RSVD, 8'h00);
    send_word(KIND_BYTE, 8'hAA);
    send_word(KIND_END, 8'hFF);
  endtask

  // lengths around the point where the length field no longer fits,
  // and exactly one full block
  task automatic test_block_boundaries();
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
  endtask

  // mixed lengths, mostly short, some crossing one or two blocks;
  // idling on either side switched per message
  task automatic test_random_messages(input int unsigned n_words);
    int unsigned start;
    int unsigned sel;
    start = words_sent;
    while (words_sent - start < n_words) begin
      src_idle_en = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 9);
      if (sel < 7)
        send_message($urandom_range(0, 12));
      else if (sel < 9)
        send_message($urandom_range(13, 70));
      else
        send_message($urandom_range(100, 130));
    end
  endtask

  // closing stretch at full speed on both sides
  task automatic test_full_rate(input int unsigned n_words);
    int unsigned start;
    start = words_sent;
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    while (words_sent - start < n_words) send_message($urandom_range(0, 20));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_message();
    test_short_message();
    test_byte_extremes();
    test_reserved_kind();
    test_block_boundaries();
    test_random_messages(20);
    test_full_rate(20);

    in_valid <= 1'b0;
    while (digest_exp_q.size() != 0) @(posedge clk);
    // a final word must not be followed by anything stray
    repeat (200) @(posedge clk);

    $display("hashed %0d messages from %0d words, %0d digest words checked",
             messages_hashed, words_sent, digest_words_checked);
    $display("covered empty, one-byte, padding-spill and multi-block messages, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("timeout with %0d digest words outstanding", digest_exp_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sha1_hash.f
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_round.sv
hw/rtl/sha1_wbuf.sv
hw/rtl/sha1_hash.sv
tb/tb_top.sv
